FILE: rtl/core/assert_macros.svh
// assertion macros shared by the plane unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define PFTP_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion failed: forbidden condition");

// antecedent implies consequent in the same cycle
`define PFTP_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`endif

FILE: rtl/core/pftp_pkg.sv
// shared widths, constants and item types of the plane unit
`default_nettype none
package pftp_pkg;

   localparam int CRD_W          = 12;
   localparam int COORD_BITS_DEF = 12;
   localparam int DIFF_W         = CRD_W + 1;
   localparam int PROD_W         = 2 * DIFF_W;
   localparam int NRM_W          = PROD_W;
   localparam int MAG_W          = NRM_W - 1;
   localparam int SQ1_W          = 2 * MAG_W;
   localparam int SQ_W           = SQ1_W + 2;
   localparam int ROOT_W         = SQ_W / 2;
   localparam int REM_W          = ROOT_W + 3;
   localparam int DOTT_W         = NRM_W + CRD_W;
   localparam int DOT_W          = DOTT_W + 2;
   localparam int NUM_W          = 56;
   localparam int QUO_W          = 31;
   localparam int OUT_W          = 32;
   localparam int OFS_W          = 29;
   localparam int NRM_FRAC       = 30;
   localparam int OFS_FRAC       = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int QCNT_W         = 3;

   localparam logic [OFS_W-1:0] OFS_POS_SAT = {1'b0, {(OFS_W-1){1'b1}}};
   localparam logic [OFS_W-1:0] OFS_NEG_SAT = {1'b1, {(OFS_W-1){1'b0}}};
   localparam logic [QUO_W-1:0] OFS_LIMIT   = QUO_W'(1) << (OFS_W - 1);

   // item handed from the front part to the back part
   typedef struct packed {
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic signed [CRD_W-1:0] x1;
      logic signed [CRD_W-1:0] y1;
      logic signed [CRD_W-1:0] z1;
      logic                    collinear;
   } front_item_type;

   // values carried alongside the square root pipeline
   typedef struct packed {
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic signed [DOT_W-1:0] dot;
      logic                    collinear;
   } sqrt_side_type;

   // control carried alongside the divider lanes
   typedef struct packed {
      logic valid;
      logic sign_a;
      logic sign_b;
      logic sign_c;
      logic sign_d;
      logic ovf;
      logic collinear;
   } div_side_type;

endpackage
`default_nettype wire

FILE: rtl/core/pftp_front.sv
// front part: accepts point triples, forms edge vectors and cross product
`default_nettype none
module pftp_front #(
   parameter int COORD_BITS = pftp_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_z,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_z,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_z,
   input  wire logic [pftp_pkg::QCNT_W-1:0]   queue_level,
   output logic                               push_valid,
   output pftp_pkg::front_item_type           push_item
);

   localparam int SH = pftp_pkg::CRD_W - COORD_BITS;

   logic signed [pftp_pkg::CRD_W-1:0]  raw [9];
   logic signed [pftp_pkg::CRD_W-1:0]  crd [9];
   logic signed [pftp_pkg::CRD_W-1:0]  tmp [9];
   logic                               accept;

   logic                               a_valid_ff;
   logic signed [pftp_pkg::CRD_W-1:0]  a_p1_ff [3];
   logic signed [pftp_pkg::DIFF_W-1:0] a_u_ff [3];
   logic signed [pftp_pkg::DIFF_W-1:0] a_v_ff [3];

   logic                               b_valid_ff;
   logic signed [pftp_pkg::CRD_W-1:0]  b_p1_ff [3];
   logic signed [pftp_pkg::PROD_W-1:0] b_prd_ff [6];
   logic signed [pftp_pkg::PROD_W-1:0] prd_in [6];
   logic signed [pftp_pkg::PROD_W:0]   n_w [3];

   assign raw[0] = req_first_x;
   assign raw[1] = req_first_y;
   assign raw[2] = req_first_z;
   assign raw[3] = req_second_x;
   assign raw[4] = req_second_y;
   assign raw[5] = req_second_z;
   assign raw[6] = req_third_x;
   assign raw[7] = req_third_y;
   assign raw[8] = req_third_z;

   // sign extension from the configured coordinate width
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         tmp[i] = raw[i] <<< SH;
         crd[i] = tmp[i] >>> SH;
      end
   end

   // hold off when queue space could run out for items in flight
   assign busy = (pftp_pkg::QCNT_W'(queue_level) + pftp_pkg::QCNT_W'(a_valid_ff)
                  + pftp_pkg::QCNT_W'(b_valid_ff)) >= pftp_pkg::QCNT_W'(pftp_pkg::QUEUE_DEPTH);
   assign accept = start && !busy;

   // stage a: edge vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      for (int i = 0; i < 3; i++) begin
         a_p1_ff[i] <= crd[i];
         a_u_ff[i]  <= pftp_pkg::DIFF_W'(crd[3+i]) - pftp_pkg::DIFF_W'(crd[i]);
         a_v_ff[i]  <= pftp_pkg::DIFF_W'(crd[6+i]) - pftp_pkg::DIFF_W'(crd[i]);
      end
   end

   // partial products of the cross product
   always_comb begin
      prd_in[0] = a_u_ff[1] * a_v_ff[2];
      prd_in[1] = a_u_ff[2] * a_v_ff[1];
      prd_in[2] = a_u_ff[2] * a_v_ff[0];
      prd_in[3] = a_u_ff[0] * a_v_ff[2];
      prd_in[4] = a_u_ff[0] * a_v_ff[1];
      prd_in[5] = a_u_ff[1] * a_v_ff[0];
   end

   // stage b: registered products
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_p1_ff  <= a_p1_ff;
      b_prd_ff <= prd_in;
   end

   // normal components and collinear classification
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_w[i] = (pftp_pkg::PROD_W+1)'(b_prd_ff[2*i])
                - (pftp_pkg::PROD_W+1)'(b_prd_ff[2*i+1]);
      end
      push_valid          = b_valid_ff;
      push_item.nx        = n_w[0][pftp_pkg::NRM_W-1:0];
      push_item.ny        = n_w[1][pftp_pkg::NRM_W-1:0];
      push_item.nz        = n_w[2][pftp_pkg::NRM_W-1:0];
      push_item.x1        = b_p1_ff[0];
      push_item.y1        = b_p1_ff[1];
      push_item.z1        = b_p1_ff[2];
      push_item.collinear = (n_w[0] == '0) && (n_w[1] == '0) && (n_w[2] == '0);
   end

endmodule
`default_nettype wire

FILE: rtl/core/pftp_queue.sv
// short item queue between front and back parts
`default_nettype none
`include "assert_macros.svh"
module pftp_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  pftp_pkg::front_item_type           push_item,
   output logic                               pop_valid,
   output pftp_pkg::front_item_type           pop_item,
   output logic [pftp_pkg::QCNT_W-1:0]        level
);

   pftp_pkg::front_item_type            mem_ff [pftp_pkg::QUEUE_DEPTH];
   logic [pftp_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [pftp_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [pftp_pkg::QCNT_W-1:0]         level_ff;
   logic [pftp_pkg::QCNT_W-1:0]         level_in;

   // back part takes the head whenever there is one
   assign pop_valid = (level_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      level_in = level_ff;
      if (push_valid && !pop_valid) begin
         level_in = level_ff + 1'b1;
      end else if (!push_valid && pop_valid) begin
         level_in = level_ff - 1'b1;
      end
   end

   // pointers and level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `PFTP_ASSERT_NEVER(a_no_overflow, push_valid && !pop_valid && (level_ff == pftp_pkg::QCNT_W'(pftp_pkg::QUEUE_DEPTH)))
   `PFTP_ASSERT_NEVER(a_level_ptrs, level_ff[pftp_pkg::QPTR_W-1:0] != (wr_ptr_ff - rd_ptr_ff))

endmodule
`default_nettype wire

FILE: rtl/core/pftp_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module pftp_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [pftp_pkg::SQ_W-1:0]     in_x,
   input  pftp_pkg::sqrt_side_type            in_side,
   output logic                               out_valid,
   output logic [pftp_pkg::ROOT_W-1:0]        out_root,
   output pftp_pkg::sqrt_side_type            out_side
);

   localparam int N = pftp_pkg::ROOT_W;

   logic                              vld [N+1];
   logic [pftp_pkg::REM_W-1:0]        rem [N+1];
   logic [pftp_pkg::ROOT_W-1:0]       root [N+1];
   logic [pftp_pkg::SQ_W-1:0]         xs [N+1];
   pftp_pkg::sqrt_side_type           side [N+1];

   assign vld[0]  = in_valid;
   assign rem[0]  = '0;
   assign root[0] = '0;
   assign xs[0]   = in_x;
   assign side[0] = in_side;

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [pftp_pkg::REM_W-1:0] shifted;
      logic [pftp_pkg::REM_W-1:0] trial;
      logic                       ge;

      // bring down two radicand bits and try the next root bit
      assign shifted = {rem[s][pftp_pkg::REM_W-3:0], xs[s][pftp_pkg::SQ_W-1 -: 2]};
      assign trial   = {{(pftp_pkg::REM_W-pftp_pkg::ROOT_W-2){1'b0}}, root[s], 2'b01};
      assign ge      = shifted >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld[s+1] <= 1'b0;
         end else begin
            vld[s+1] <= vld[s];
         end
         rem[s+1]  <= ge ? shifted - trial : shifted;
         root[s+1] <= {root[s][pftp_pkg::ROOT_W-2:0], ge};
         xs[s+1]   <= xs[s] << 2;
         side[s+1] <= side[s];
      end
   end

   assign out_valid = vld[N];
   assign out_root  = root[N];
   assign out_side  = side[N];

endmodule
`default_nettype wire

FILE: rtl/core/pftp_div.sv
// pipelined restoring divider lane, one quotient bit per stage
`default_nettype none
module pftp_div (
   input  wire logic                          clock,
   input  wire logic [pftp_pkg::NUM_W-1:0]    num,
   input  wire logic [pftp_pkg::ROOT_W-1:0]   den,
   output logic [pftp_pkg::QUO_W-1:0]         quo
);

   localparam int N = pftp_pkg::QUO_W;

   logic [pftp_pkg::NUM_W-1:0]   rem [N+1];
   logic [pftp_pkg::ROOT_W-1:0]  dv [N+1];
   logic [pftp_pkg::QUO_W-1:0]   q [N+1];

   assign rem[0] = num;
   assign dv[0]  = den;
   assign q[0]   = '0;

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [pftp_pkg::NUM_W:0] den_sh;
      logic                     ge;

      // compare against the divisor aligned to this quotient bit
      assign den_sh = (pftp_pkg::NUM_W+1)'(dv[s]) << (N - 1 - s);
      assign ge     = {1'b0, rem[s]} >= den_sh;

      always_ff @(posedge clock) begin
         rem[s+1] <= ge ? rem[s] - den_sh[pftp_pkg::NUM_W-1:0] : rem[s];
         dv[s+1]  <= dv[s];
         q[s+1]   <= {q[s][pftp_pkg::QUO_W-2:0], ge};
      end
   end

   assign quo = q[N];

endmodule
`default_nettype wire

FILE: rtl/core/pftp_back.sv
// back part: length, normalization, offset and result register
`default_nettype none
`include "assert_macros.svh"
module pftp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   input  pftp_pkg::front_item_type           pop_item,
   output logic                               rsp_valid,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_x,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_y,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_z,
   output logic [pftp_pkg::OFS_W-1:0]         rsp_offset,
   output logic                               rsp_collinear
);

   localparam int ND = pftp_pkg::QUO_W;

   // stage 1 registers
   logic                                s1_valid_ff;
   logic [pftp_pkg::SQ1_W-1:0]          s1_sq_ff [3];
   logic signed [pftp_pkg::DOTT_W-1:0]  s1_dt_ff [3];
   pftp_pkg::sqrt_side_type             s1_side_ff;
   logic signed [2*pftp_pkg::NRM_W-1:0] sq_in [3];
   logic signed [pftp_pkg::DOTT_W-1:0]  dt_in [3];

   // stage 2 registers
   logic                                s2_valid_ff;
   logic [pftp_pkg::SQ_W-1:0]           s2_sum_ff;
   pftp_pkg::sqrt_side_type             s2_side_ff;

   logic                                rt_valid;
   logic [pftp_pkg::ROOT_W-1:0]         rt_root;
   pftp_pkg::sqrt_side_type             rt_side;

   // prep registers feeding the divider lanes
   logic [pftp_pkg::NUM_W-1:0]          num_ff [4];
   logic [pftp_pkg::ROOT_W-1:0]         den_ff;
   logic [pftp_pkg::NUM_W-1:0]          num_in [4];
   logic [pftp_pkg::ROOT_W-1:0]         half;
   logic signed [pftp_pkg::NRM_W-1:0]   nrm [3];
   logic [pftp_pkg::NRM_W-1:0]          mag [3];
   logic [pftp_pkg::DOT_W-1:0]          mag_d;
   logic                                ovf_in;
   pftp_pkg::div_side_type              dside [ND+1];
   logic [pftp_pkg::QUO_W-1:0]          quo [4];

   // result register
   logic                                rsp_valid_ff;
   logic [pftp_pkg::OUT_W-1:0]          rsp_normal_x_ff;
   logic [pftp_pkg::OUT_W-1:0]          rsp_normal_y_ff;
   logic [pftp_pkg::OUT_W-1:0]          rsp_normal_z_ff;
   logic [pftp_pkg::OFS_W-1:0]          rsp_offset_ff;
   logic                                rsp_collinear_ff;
   logic [pftp_pkg::OFS_W-1:0]          ofs_in;
   logic                                ofs_sat;

   // squares and dot terms
   always_comb begin
      sq_in[0] = pop_item.nx * pop_item.nx;
      sq_in[1] = pop_item.ny * pop_item.ny;
      sq_in[2] = pop_item.nz * pop_item.nz;
      dt_in[0] = pop_item.nx * pftp_pkg::DOTT_W'(pop_item.x1);
      dt_in[1] = pop_item.ny * pftp_pkg::DOTT_W'(pop_item.y1);
      dt_in[2] = pop_item.nz * pftp_pkg::DOTT_W'(pop_item.z1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s1_sq_ff[i] <= sq_in[i][pftp_pkg::SQ1_W-1:0];
         s1_dt_ff[i] <= dt_in[i];
      end
      s1_side_ff.nx        <= pop_item.nx;
      s1_side_ff.ny        <= pop_item.ny;
      s1_side_ff.nz        <= pop_item.nz;
      s1_side_ff.dot       <= '0;
      s1_side_ff.collinear <= pop_item.collinear;
      // squared length and dot product sums
      s2_sum_ff <= pftp_pkg::SQ_W'(s1_sq_ff[0]) + pftp_pkg::SQ_W'(s1_sq_ff[1])
                 + pftp_pkg::SQ_W'(s1_sq_ff[2]);
      s2_side_ff.nx        <= s1_side_ff.nx;
      s2_side_ff.ny        <= s1_side_ff.ny;
      s2_side_ff.nz        <= s1_side_ff.nz;
      s2_side_ff.collinear <= s1_side_ff.collinear;
      s2_side_ff.dot <= pftp_pkg::DOT_W'(s1_dt_ff[0]) + pftp_pkg::DOT_W'(s1_dt_ff[1])
                      + pftp_pkg::DOT_W'(s1_dt_ff[2]);
   end

   pftp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_x      (s2_sum_ff),
      .in_side   (s2_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // rounded numerators, magnitudes and offset overflow check
   always_comb begin
      half   = rt_root >> 1;
      nrm[0] = rt_side.nx;
      nrm[1] = rt_side.ny;
      nrm[2] = rt_side.nz;
      for (int i = 0; i < 3; i++) begin
         mag[i]    = nrm[i][pftp_pkg::NRM_W-1] ? pftp_pkg::NRM_W'(-nrm[i])
                                               : pftp_pkg::NRM_W'(nrm[i]);
         num_in[i] = pftp_pkg::NUM_W'({mag[i][pftp_pkg::MAG_W-1:0],
                                       {pftp_pkg::NRM_FRAC{1'b0}}})
                   + pftp_pkg::NUM_W'(half);
      end
      mag_d     = rt_side.dot[pftp_pkg::DOT_W-1] ? pftp_pkg::DOT_W'(-rt_side.dot)
                                                 : pftp_pkg::DOT_W'(rt_side.dot);
      num_in[3] = pftp_pkg::NUM_W'({mag_d[pftp_pkg::DOT_W-2:0],
                                    {pftp_pkg::OFS_FRAC{1'b0}}})
                + pftp_pkg::NUM_W'(half);
      ovf_in    = {1'b0, num_in[3]} >= {rt_root, {pftp_pkg::QUO_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dside[0].valid <= 1'b0;
      end else begin
         dside[0].valid <= rt_valid;
      end
      dside[0].sign_a    <= rt_side.nx[pftp_pkg::NRM_W-1];
      dside[0].sign_b    <= rt_side.ny[pftp_pkg::NRM_W-1];
      dside[0].sign_c    <= rt_side.nz[pftp_pkg::NRM_W-1];
      dside[0].sign_d    <= !rt_side.dot[pftp_pkg::DOT_W-1] && (rt_side.dot != '0);
      dside[0].ovf       <= ovf_in;
      dside[0].collinear <= rt_side.collinear;
      num_ff <= num_in;
      den_ff <= rt_root;
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      pftp_div u_div (
         .clock (clock),
         .num   (num_ff[l]),
         .den   (den_ff),
         .quo   (quo[l])
      );
   end

   // control delay line matching the divider latency
   for (genvar s = 0; s < ND; s++) begin : g_dside
      always_ff @(posedge clock) begin
         if (reset) begin
            dside[s+1].valid <= 1'b0;
         end else begin
            dside[s+1].valid <= dside[s].valid;
         end
         dside[s+1].sign_a    <= dside[s].sign_a;
         dside[s+1].sign_b    <= dside[s].sign_b;
         dside[s+1].sign_c    <= dside[s].sign_c;
         dside[s+1].sign_d    <= dside[s].sign_d;
         dside[s+1].ovf       <= dside[s].ovf;
         dside[s+1].collinear <= dside[s].collinear;
      end
   end

   // offset sign and saturation
   always_comb begin
      if (dside[ND].sign_d) begin
         ofs_sat = dside[ND].ovf || (quo[3] > pftp_pkg::OFS_LIMIT);
         ofs_in  = ofs_sat ? pftp_pkg::OFS_NEG_SAT : pftp_pkg::OFS_W'(-quo[3]);
      end else begin
         ofs_sat = dside[ND].ovf || (quo[3] >= pftp_pkg::OFS_LIMIT);
         ofs_in  = ofs_sat ? pftp_pkg::OFS_POS_SAT : pftp_pkg::OFS_W'(quo[3]);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dside[ND].valid;
      end
      rsp_collinear_ff <= dside[ND].collinear;
      if (dside[ND].collinear) begin
         rsp_normal_x_ff <= '0;
         rsp_normal_y_ff <= '0;
         rsp_normal_z_ff <= '0;
         rsp_offset_ff   <= '0;
      end else begin
         // widen before negating so the sign reaches the top bit
         rsp_normal_x_ff <= dside[ND].sign_a ? -(pftp_pkg::OUT_W'(quo[0]))
                                             : pftp_pkg::OUT_W'(quo[0]);
         rsp_normal_y_ff <= dside[ND].sign_b ? -(pftp_pkg::OUT_W'(quo[1]))
                                             : pftp_pkg::OUT_W'(quo[1]);
         rsp_normal_z_ff <= dside[ND].sign_c ? -(pftp_pkg::OUT_W'(quo[2]))
                                             : pftp_pkg::OUT_W'(quo[2]);
         rsp_offset_ff   <= ofs_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_normal_x  = rsp_normal_x_ff;
   assign rsp_normal_y  = rsp_normal_y_ff;
   assign rsp_normal_z  = rsp_normal_z_ff;
   assign rsp_offset    = rsp_offset_ff;
   assign rsp_collinear = rsp_collinear_ff;

   `PFTP_ASSERT_IMPLIES(a_coll_zero, rsp_valid_ff && rsp_collinear_ff, (rsp_normal_x_ff == '0) && (rsp_normal_y_ff == '0) && (rsp_normal_z_ff == '0) && (rsp_offset_ff == '0))
   `PFTP_ASSERT_IMPLIES(a_normal_nonzero, rsp_valid_ff && !rsp_collinear_ff, (rsp_normal_x_ff != '0) || (rsp_normal_y_ff != '0) || (rsp_normal_z_ff != '0))

endmodule
`default_nettype wire

FILE: rtl/core/plane_from_three_points_unit.sv
// top level of the plane through three points unit
//
// Usage: drive the nine req_ coordinate ports and raise start; the item is
// taken at a rising edge where start is high and busy is low. Only the low
// COORD_BITS bits of each coordinate count, sign-extended.
// Each result appears on the rsp_ ports for exactly one cycle while
// rsp_valid is high: unit normal in Q2.30, offset in Q13.16 (saturated),
// and rsp_collinear with all coefficients zero for collinear points.
// Results come out in input order.
// From the accepting edge to the edge that takes the result the item passes
// 2 front stages, the queue, 2 stages of squares and sums, 26 square root
// stages (one root bit each), 1 rounding stage, 31 divider stages (one
// quotient bit each, four lanes in parallel) and the result register.
// Throughput: one item per cycle unless busy; the divider and square
// root pipelines accept a new operand every cycle and the queue drains
// every cycle, so busy stays low in normal operation. busy rises only if
// the queue and the front stages in flight could exceed the four entries.
// Reset (synchronous) empties the queue and clears all valid flags; no
// result is lost to a receiver stall because the receiver cannot stall.
`default_nettype none
module plane_from_three_points_unit #(
   parameter int COORD_BITS = pftp_pkg::COORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_first_z,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_second_z,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_x,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_y,
   input  wire logic [pftp_pkg::CRD_W-1:0]    req_third_z,
   output logic                               rsp_valid,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_x,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_y,
   output logic [pftp_pkg::OUT_W-1:0]         rsp_normal_z,
   output logic [pftp_pkg::OFS_W-1:0]         rsp_offset,
   output logic                               rsp_collinear
);

   logic                          push_valid;
   pftp_pkg::front_item_type      push_item;
   logic                          pop_valid;
   pftp_pkg::front_item_type      pop_item;
   logic [pftp_pkg::QCNT_W-1:0]   level;

   // accept and classify
   pftp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_first_z  (req_first_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .req_third_x  (req_third_x),
      .req_third_y  (req_third_y),
      .req_third_z  (req_third_z),
      .queue_level  (level),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   // decoupling queue
   pftp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (level)
   );

   // normalization and offset
   pftp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_normal_x  (rsp_normal_x),
      .rsp_normal_y  (rsp_normal_y),
      .rsp_normal_z  (rsp_normal_z),
      .rsp_offset    (rsp_offset),
      .rsp_collinear (rsp_collinear)
   );

endmodule
`default_nettype wire

FILE: tb/plane_from_three_points_unit_tb.sv
// testbench of the plane through three points unit: table-driven directed items, then random
`default_nettype none
module plane_from_three_points_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1850;
   localparam int SETTLE   = 80;
   localparam int N_DIR    = 20;

   // one plane result
   typedef struct packed {
      logic [pftp_pkg::OUT_W-1:0] nx;
      logic [pftp_pkg::OUT_W-1:0] ny;
      logic [pftp_pkg::OUT_W-1:0] nz;
      logic [pftp_pkg::OFS_W-1:0] ofs;
      logic                       col;
   } plane_type;

   // nine coordinates of one item
   typedef logic [pftp_pkg::CRD_W-1:0] coord_set_type [9];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pftp_pkg::CRD_W-1:0] crd [9];
   logic rsp_valid;
   logic [pftp_pkg::OUT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [pftp_pkg::OFS_W-1:0] rsp_offset;
   logic rsp_collinear;

   plane_type planes_due [$];
   int mismatches = 0;
   bit all_sent = 1'b0;

   plane_from_three_points_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(crd[0]), .req_first_y(crd[1]), .req_first_z(crd[2]),
      .req_second_x(crd[3]), .req_second_y(crd[4]), .req_second_z(crd[5]),
      .req_third_x(crd[6]), .req_third_y(crd[7]), .req_third_z(crd[8]),
      .rsp_valid(rsp_valid), .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_offset(rsp_offset), .rsp_collinear(rsp_collinear)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded division, ties away from zero
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // floor of the square root
   function automatic longint floor_root(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
            r = r + (longint'(1) << b);
      end
      return r;
   endfunction

   // plane through the three points of one item
   function automatic plane_type plane_of(coord_set_type c);
      longint p [9];
      longint ux, uy, uz, vx, vy, vz, nx, ny, nz, len, d;
      plane_type r;
      for (int i = 0; i < 9; i++) p[i] = longint'($signed(c[i]));
      ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
      vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      r = '0;
      if (nx == 0 && ny == 0 && nz == 0) begin
         r.col = 1'b1;
         return r;
      end
      len = floor_root(nx * nx + ny * ny + nz * nz);
      r.nx = pftp_pkg::OUT_W'(round_div(nx * (longint'(1) << pftp_pkg::NRM_FRAC), len));
      r.ny = pftp_pkg::OUT_W'(round_div(ny * (longint'(1) << pftp_pkg::NRM_FRAC), len));
      r.nz = pftp_pkg::OUT_W'(round_div(nz * (longint'(1) << pftp_pkg::NRM_FRAC), len));
      d = round_div(-(nx * p[0] + ny * p[1] + nz * p[2]) * (longint'(1) << pftp_pkg::OFS_FRAC),
                    len);
      if (d > 268435455) d = 268435455;
      if (d < -268435456) d = -268435456;
      r.ofs = pftp_pkg::OFS_W'(d);
      return r;
   endfunction

   // directed table: coordinates and, where obvious, the typed-in result
   coord_set_type dir_pts [N_DIR];
   plane_type dir_exp [N_DIR];
   bit dir_typed [N_DIR];

   initial begin
      dir_typed = '{default: 1'b0};
      // all points equal at zero: collinear
      dir_pts[0] = '{default: 12'h000};
      dir_exp[0] = '{nx: '0, ny: '0, nz: '0, ofs: '0, col: 1'b1};
      dir_typed[0] = 1'b1;
      // all equal at the extremes
      dir_pts[1] = '{default: 12'h800};
      dir_exp[1] = '{nx: '0, ny: '0, nz: '0, ofs: '0, col: 1'b1};
      dir_typed[1] = 1'b1;
      dir_pts[2] = '{default: 12'h7ff};
      dir_exp[2] = '{nx: '0, ny: '0, nz: '0, ofs: '0, col: 1'b1};
      dir_typed[2] = 1'b1;
      // xy plane through origin: normal +z, offset zero
      dir_pts[3] = '{12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0};
      dir_exp[3] = '{nx: '0, ny: '0, nz: 32'h4000_0000, ofs: '0, col: 1'b0};
      dir_typed[3] = 1'b1;
      // same, swapped order: normal -z
      dir_pts[4] = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'd0};
      dir_exp[4] = '{nx: '0, ny: '0, nz: 32'hc000_0000, ofs: '0, col: 1'b0};
      dir_typed[4] = 1'b1;
      // collinear on a long diagonal
      dir_pts[5] = '{12'h800, 12'h800, 12'h800, 12'd0, 12'd0, 12'd0,
                     12'h7ff, 12'h7ff, 12'h7ff};
      // extreme spread corners
      dir_pts[6] = '{12'h800, 12'h800, 12'h800, 12'h7ff, 12'h800, 12'h800,
                     12'h800, 12'h7ff, 12'h800};
      dir_pts[7] = '{12'h7ff, 12'h7ff, 12'h7ff, 12'h800, 12'h7ff, 12'h7ff,
                     12'h7ff, 12'h800, 12'h7ff};
      dir_pts[8] = '{12'h800, 12'h7ff, 12'h800, 12'h7ff, 12'h800, 12'h7ff,
                     12'h7ff, 12'h7ff, 12'h800};
      // tiny normal far from origin
      dir_pts[9] = '{12'h7ff, 12'h7ff, 12'h7ff, 12'h7fe, 12'h7ff, 12'h7ff,
                     12'h7ff, 12'h7fe, 12'h7ff};
      dir_pts[10] = '{12'h800, 12'h800, 12'h800, 12'h801, 12'h800, 12'h800,
                      12'h800, 12'h801, 12'h800};
      dir_pts[11] = '{12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7fe, 12'h7ff,
                      12'h7ff, 12'h7ff, 12'h7fe};
      dir_pts[12] = '{12'h800, 12'h7ff, 12'h000, 12'h801, 12'h7fe, 12'h001,
                      12'h801, 12'h7ff, 12'h000};
      // non-exact root, small vectors
      dir_pts[13] = '{12'd5, 12'd3, 12'hffe, 12'd6, 12'd4, 12'hffe, 12'd5, 12'd4, 12'hfff};
      dir_pts[14] = '{12'd0, 12'd0, 12'd0, 12'd1, 12'd2, 12'd3, 12'd3, 12'd2, 12'd1};
      dir_pts[15] = '{12'd100, 12'd200, 12'd300, 12'd101, 12'd200, 12'd300,
                      12'd100, 12'd201, 12'd301};
      // two points equal: collinear
      dir_pts[16] = '{12'd7, 12'd8, 12'd9, 12'd7, 12'd8, 12'd9, 12'h123, 12'h456, 12'h789};
      // alternating and edge bit patterns
      dir_pts[17] = '{default: 12'haaa};
      dir_pts[17][3] = 12'h555; dir_pts[17][7] = 12'h555;
      dir_pts[18] = '{12'h555, 12'haaa, 12'h555, 12'haaa, 12'h555, 12'haaa,
                      12'h555, 12'h555, 12'haaa};
      dir_pts[19] = '{12'hfff, 12'h001, 12'hfff, 12'h001, 12'hfff, 12'h001,
                      12'h7ff, 12'h800, 12'h000};
   end

   // present one item from a falling edge until the rising edge that takes it
   task automatic send_item(coord_set_type c, plane_type want);
      crd = c;
      start <= 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      planes_due.push_back(want);
      @(negedge clock);
   endtask

   // random coordinates: mostly full range, some near-collinear or clustered
   function automatic coord_set_type random_points();
      coord_set_type c;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) c[i] = pftp_pkg::CRD_W'($urandom);
      if (kind == 0) begin
         // third point on the line of the first two
         for (int i = 0; i < 3; i++) c[6 + i] = c[i] + 2 * (c[3 + i] - c[i]);
      end else if (kind < 3) begin
         // cluster around the first point
         for (int i = 3; i < 9; i++)
            c[i] = c[i % 3] + pftp_pkg::CRD_W'($urandom_range(0, 6) - 3);
      end
      return c;
   endfunction

   // stimulus
   initial begin
      coord_set_type c;
      crd = '{default: '0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIR; i++)
         send_item(dir_pts[i], dir_typed[i] ? dir_exp[i] : plane_of(dir_pts[i]));
      // drain before the random part
      start <= 1'b0;
      @(negedge clock);
      while (planes_due.size() != 0) @(negedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         if ((i < 400 || i > 700) && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         if (i == 1000) begin
            start <= 1'b0;
            @(negedge clock);
            while (planes_due.size() != 0) @(negedge clock);
         end
         c = random_points();
         send_item(c, plane_of(c));
      end
      start <= 1'b0;
      all_sent = 1'b1;
   end

   // result check
   always @(posedge clock) begin
      plane_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_offset, rsp_collinear};
         if (planes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = planes_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: nx %h/%h ny %h/%h nz %h/%h ofs %h/%h col %b/%b",
                           want.nx, got.nx, want.ny, got.ny, want.nz, got.nz,
                           want.ofs, got.ofs, want.col, got.col);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (all_sent);
      while (planes_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("plane_from_three_points_unit_tb OK");
      else
         $display("plane_from_three_points_unit_tb NOT OK");
      $finish;
   end

   // run limit
   initial begin
      #2ms;
      $display("plane_from_three_points_unit_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/pftp_pkg.sv
rtl/core/pftp_front.sv
rtl/core/pftp_queue.sv
rtl/core/pftp_isqrt.sv
rtl/core/pftp_div.sv
rtl/core/pftp_back.sv
rtl/core/plane_from_three_points_unit.sv
tb/plane_from_three_points_unit_tb.sv
